// ----- rtl/abavg_pkg.sv -----
// Shared types and constants of the converter burst averager.
// Depends on nothing; every other file of the block imports it.
package abavg_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int CORR_BITS     = SAMPLE_BITS + 1;
	localparam int SUM_BITS      = 29;
	localparam int LEN_BITS      = 16;
	localparam int DIV_BITS      = LEN_BITS + 1;
	localparam int FRAC_BITS     = 8;
	localparam int DVD_BITS      = SUM_BITS + FRAC_BITS;
	localparam int MEAN_BITS     = 21;
	localparam int CNT_BITS      = $clog2(DVD_BITS);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [MEAN_BITS-1:0] MEAN_MAX = MEAN_BITS'(1056512);

	localparam logic [CFG_IDX_BITS-1:0] REG_BURST_LENGTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DROP_LEAD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COMPENSATE = 2'd2;

	typedef struct packed {
		logic [LEN_BITS-1:0] burst_length;
		logic                drop_lead;
		logic                compensate_enable;
	} cfg_t;

	typedef struct packed {
		logic                go;
		logic [SUM_BITS-1:0] sum;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

// ----- rtl/adc_burst_averager.sv -----
// Top level of the converter burst averager: configuration registers and handshakes.
// Depends on abavg_pkg, abavg_acc and abavg_div.
//
// The block averages 12-bit converter samples over bursts of burst_length kept samples
// (zero means 65536) and returns floor(sum * 256 / length), saturated at 1056512, as one
// beat on the output channel. With drop_lead set, the first sample of each burst is
// dropped; with compensate_enable set, each kept sample is first corrected around the
// 512/1536/2560/3584 code steps. The beat that ends a burst starts a restoring divider
// that retires one quotient bit per cycle over the 37-bit scaled sum, so in_ready stays
// low while it runs and until its result can enter the output register, where a
// previous result may still wait to be taken. Samples keep being accepted while a
// finished mean waits to be taken, as long as no further burst completes. Configuration
// writes are always accepted (cfg_ready is tied high) and take effect at once; write
// them only while the block is idle. Register indexes: 0 burst_length, 1 drop_lead,
// 2 compensate_enable; other indexes are ignored.
module adc_burst_averager (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [abavg_pkg::SAMPLE_BITS-1:0]      sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [abavg_pkg::MEAN_BITS-1:0]        mean_value,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [abavg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [abavg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import abavg_pkg::*;

	cfg_t     cfg_q;
	div_req_t req;
	logic     div_busy;
	logic     in_fire;
	logic     cfg_fire;

	// hold off samples while the divider works on a finished burst
	assign in_ready  = !div_busy;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// register file: reset to 64 samples, discard on, correction on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_length      <= LEN_BITS'(64);
			cfg_q.drop_lead         <= 1'b1;
			cfg_q.compensate_enable <= 1'b1;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_BURST_LENGTH: cfg_q.burst_length      <= cfg_data[LEN_BITS-1:0];
				REG_DROP_LEAD:    cfg_q.drop_lead         <= cfg_data[0];
				REG_COMPENSATE:   cfg_q.compensate_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// accumulate kept samples; flag the beat that completes a burst
	abavg_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.sample  (sample),
		.cfg     (cfg_q),
		.req     (req)
	);

	// divide, saturate and present the mean
	abavg_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.busy       (div_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean_value (mean_value)
	);

endmodule

// ----- rtl/abavg_acc.sv -----
// Burst accumulator: discard of the first sample, missing-code correction, sum and count.
// Depends on abavg_pkg; hands a finished burst to abavg_div.
module abavg_acc (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_fire,
	input  logic [abavg_pkg::SAMPLE_BITS-1:0]     sample,
	input  abavg_pkg::cfg_t                       cfg,
	output abavg_pkg::div_req_t                   req
);
	import abavg_pkg::*;

	logic [SUM_BITS-1:0]  running_sum_q;
	logic [LEN_BITS-1:0]  kept_count_q;
	logic                 discard_pending_q;

	logic [CORR_BITS-1:0] corr;
	logic [SUM_BITS-1:0]  sum_nxt;
	logic [DIV_BITS-1:0]  count_nxt;
	logic [DIV_BITS-1:0]  len;
	logic                 drop;
	logic                 keep;
	logic                 complete;

	function automatic logic [CORR_BITS-1:0] correct_code(input logic [SAMPLE_BITS-1:0] s);
		logic [CORR_BITS-1:0] x;
		x = {1'b0, s};
		if (s > 12'd3584)       return x + 13'd32;
		else if (s == 12'd3583) return x + 13'd29;
		else if (s == 12'd3582) return x + 13'd27;
		else if (s > 12'd2560)  return x + 13'd24;
		else if (s == 12'd2559) return x + 13'd21;
		else if (s == 12'd2558) return x + 13'd19;
		else if (s > 12'd1536)  return x + 13'd16;
		else if (s == 12'd1535) return x + 13'd13;
		else if (s == 12'd1534) return x + 13'd11;
		else if (s > 12'd512)   return x + 13'd8;
		else if (s == 12'd511)  return x + 13'd5;
		else if (s == 12'd510)  return x + 13'd3;
		else                    return x;
	endfunction

	always_comb begin
		corr      = cfg.compensate_enable ? correct_code(sample) : {1'b0, sample};
		sum_nxt   = running_sum_q + {{(SUM_BITS-CORR_BITS){1'b0}}, corr};
		count_nxt = {1'b0, kept_count_q} + DIV_BITS'(1);
		// a zero length stands for 65536
		len       = (cfg.burst_length == '0) ? {1'b1, {LEN_BITS{1'b0}}}
		                                     : {1'b0, cfg.burst_length};
		drop      = discard_pending_q && cfg.drop_lead;
		keep      = in_fire && !drop;
		complete  = keep && (count_nxt >= len);
	end

	always_comb begin
		req.go      = complete;
		req.sum     = sum_nxt;
		req.divisor = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q     <= '0;
			kept_count_q      <= '0;
			discard_pending_q <= 1'b1;
		end else if (in_fire) begin
			discard_pending_q <= 1'b0;
			if (complete) begin
				running_sum_q     <= '0;
				kept_count_q      <= '0;
				discard_pending_q <= 1'b1;
			end else if (keep) begin
				running_sum_q <= sum_nxt;
				kept_count_q  <= count_nxt[LEN_BITS-1:0];
			end
		end
	end

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |=> (kept_count_q == '0) && (running_sum_q == '0) && discard_pending_q)
		else $error("burst end did not clear sum and count");

	a_drop_only_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && drop) |-> (kept_count_q == '0) && (running_sum_q == '0))
		else $error("sample dropped inside a burst");

	a_no_drop_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(kept_count_q != '0) |-> !discard_pending_q)
		else $error("discard armed inside a burst");

endmodule

// ----- rtl/abavg_div.sv -----
// Bit-serial restoring divider for the burst mean, with saturation and output register.
// Depends on abavg_pkg; started by abavg_acc.
module abavg_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  abavg_pkg::div_req_t                 req,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [abavg_pkg::MEAN_BITS-1:0]     mean_value
);
	import abavg_pkg::*;

	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DVD_BITS - 1);

	div_state_t           state_q;
	div_state_t           state_d;
	logic [DVD_BITS-1:0]  dvd_q;
	logic [DIV_BITS-1:0]  rem_q;
	logic [DIV_BITS-1:0]  div_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [MEAN_BITS-1:0] mean_q;
	logic                 out_valid_q;

	logic [DIV_BITS:0]    rem_sh;
	logic [DIV_BITS+1:0]  trial;
	logic                 ge;
	logic [DIV_BITS-1:0]  rem_nxt;
	logic [DVD_BITS-1:0]  dvd_nxt;
	logic                 slot_free;
	logic                 step_en;
	logic                 load_out;

	// one quotient bit per cycle; the dividend shifts out at the top while quotient bits enter
	always_comb begin
		rem_sh  = {rem_q, dvd_q[DVD_BITS-1]};
		trial   = {1'b0, rem_sh} - {2'b00, div_q};
		ge      = !trial[DIV_BITS+1];
		rem_nxt = ge ? trial[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
		dvd_nxt = {dvd_q[DVD_BITS-2:0], ge};
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: if (req.go) state_d = DIV_RUN;
			DIV_RUN:  if (cnt_q == LAST_STEP) state_d = DIV_HOLD;
			DIV_HOLD: if (slot_free) state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != DIV_IDLE);
		step_en  = (state_q == DIV_RUN);
		load_out = (state_q == DIV_HOLD) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DIV_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.go) begin
				cnt_q <= '0;
			end else if (step_en) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= {req.sum, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (step_en) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
		if (load_out) begin
			mean_q <= (dvd_q > DVD_BITS'(MEAN_MAX)) ? MEAN_MAX : dvd_q[MEAN_BITS-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_value = mean_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> (state_q == DIV_IDLE))
		else $error("divider started while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_HOLD) |-> (rem_q < div_q))
		else $error("remainder not below divisor at end of division");

	a_mean_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mean_q <= MEAN_MAX))
		else $error("mean above saturation limit");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == DIV_HOLD) |-> $past(cnt_q) == LAST_STEP)
		else $error("division ended after wrong step count");

endmodule
